// ----- sv/vgbp_pkg.sv -----
// Shared types, register map and helpers for the varint group bit packer.
package vgbp_pkg;

  // Register map
  localparam logic REG_CODE_WIDTH = 1'b0;

  // Code width limits and reset value
  localparam logic [3:0] CW_RESET = 4'd8;
  localparam logic [3:0] CW_MIN   = 4'd2;
  localparam logic [3:0] CW_MAX   = 4'd8;

  // Byte packer operations
  typedef enum logic [2:0] {
    PK_NONE,
    PK_PUSH,
    PK_FLUSH_ONE,
    PK_FLUSH_HDR,
    PK_FLUSH_FIN
  } pk_op_t;

  // Command from the sequencer to the byte packer
  typedef struct packed {
    pk_op_t     op;
    logic [7:0] code;
    logic [3:0] width;
  } pk_cmd_t;

  // Byte offered by the packer for the output stage
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       first;
    logic       last;
  } pk_res_t;

  // Clamp the register value to the supported code widths
  function automatic logic [3:0] eff_width(input logic [3:0] cw);
    logic [3:0] w;
    begin
      w = cw;
      if (cw < CW_MIN) w = CW_MIN;
      if (cw > CW_MAX) w = CW_MAX;
      return w;
    end
  endfunction

endpackage

// ----- sv/varint_group_bit_packer_core.sv -----
// Varint group bit packer: one value in, a stream of packed code bytes out.
//
// Each accepted value is cut into (code_width-1)-bit groups, top group first,
// with a continuation bit on all but the last group, and the codes are packed
// MSB-first into bytes after a 4-bit header slot in byte 0. Byte 0 is held
// back and sent, with the unused-bit count of the final byte in its top
// nibble, when a beat with in_tlast set ends the stream; the final byte
// follows. The block takes one value at a time: after the accept cycle the
// group slicer steps through all ceil(VALUE_BITS/(code_width-1)) possible group
// positions, top first; on the last value a one-byte flush follows, or header
// and final byte when byte 0 was already filled. Output stalls hold only the
// steps that produce a byte. code_width is written over the APB port while
// idle; values outside 2..8 act as the nearest limit.
module varint_group_bit_packer_core
  import vgbp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream: tdata = value, tlast = last_value
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     in_tdata,  // [VALUE_BITS-1:0] value
  input  logic                                in_tlast,
  // Output stream: tdata = out_byte, tuser = goes_first, tlast = last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata, // [7:0] out_byte
  output logic                                out_tuser, // [0] goes_first
  output logic                                out_tlast,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SHW = $clog2(VALUE_BITS);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_GROUP     = 2'd1;
  localparam logic [1:0] ST_FLUSH_HDR = 2'd2;
  localparam logic [1:0] ST_FLUSH_FIN = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [3:0]     cw_r;
  logic [3:0]     w_r;
  logic           last_r;

  logic [3:0]     w_eff;
  logic [2:0]     p_eff;
  logic [SHW-1:0] start_sh_tab [0:7];

  logic           in_fire;
  logic [7:0]     code;
  logic           code_valid;
  logic           final_grp;
  logic           step;

  pk_cmd_t        cmd;
  pk_res_t        res;
  logic           first_done;
  logic           out_free;
  logic           stall;
  logic           advance;

  logic           out_valid_r;
  logic [7:0]     out_data_r;
  logic           out_first_r;
  logic           out_last_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CODE_WIDTH) ? {28'd0, cw_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= CW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_CODE_WIDTH)) begin
      cw_r <= cfg_pwdata[3:0];
    end
  end

  // Position of the top group for every payload width
  for (genvar gp = 0; gp < 8; gp++) begin : g_start
    localparam int P   = (gp == 0) ? 1 : gp;
    localparam int GRP = (VALUE_BITS + P - 1) / P;
    assign start_sh_tab[gp] = SHW'((GRP - 1) * P);
  end

  assign w_eff   = eff_width(cw_r);
  assign p_eff   = 3'(w_eff - 4'd1);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r    <= w_eff;
      last_r <= in_tlast;
    end
  end

  vgbp_group_slicer #(
    .VALUE_BITS (VALUE_BITS),
    .SHW        (SHW)
  ) u_slicer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .value      (in_tdata[VALUE_BITS-1:0]),
    .start_sh   (start_sh_tab[p_eff]),
    .p          (3'(w_r - 4'd1)),
    .step       (step),
    .code       (code),
    .code_valid (code_valid),
    .final_grp  (final_grp)
  );

  // Sequencer command to the packer
  always_comb begin
    cmd       = '0;
    cmd.code  = code;
    cmd.width = w_r;
    unique case (state_r)
      ST_GROUP:     cmd.op = code_valid ? PK_PUSH : PK_NONE;
      ST_FLUSH_HDR: cmd.op = first_done ? PK_FLUSH_HDR : PK_FLUSH_ONE;
      ST_FLUSH_FIN: cmd.op = PK_FLUSH_FIN;
      default:      cmd.op = PK_NONE;
    endcase
  end

  vgbp_byte_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .apply      (advance),
    .res        (res),
    .first_done (first_done)
  );

  assign out_free = !out_valid_r || out_tready;
  assign stall    = res.emit && !out_free;
  assign advance  = (state_r != ST_IDLE) && !stall;
  assign step     = advance && (state_r == ST_GROUP);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_GROUP;
      end
      ST_GROUP: begin
        if (advance && final_grp) state_nxt = last_r ? ST_FLUSH_HDR : ST_IDLE;
      end
      ST_FLUSH_HDR: begin
        if (advance) state_nxt = first_done ? ST_FLUSH_FIN : ST_IDLE;
      end
      ST_FLUSH_FIN: begin
        if (advance) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (advance && res.emit) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_data_r  <= res.data;
      out_first_r <= res.first;
      out_last_r  <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_first_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/vgbp_group_slicer.sv -----
// Group slicer: shared shifter that walks a value one payload group per cycle while step is set.
module vgbp_group_slicer
  import vgbp_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int SHW        = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [SHW-1:0]        start_sh,
  input  logic [2:0]            p,
  input  logic                  step,
  output logic [7:0]            code,
  output logic                  code_valid,
  output logic                  final_grp
);

  logic [VALUE_BITS-1:0] v_r;
  logic [SHW-1:0]        sh_r;
  logic                  started_r;

  logic [VALUE_BITS-1:0] shifted;
  logic [7:0]            pmask;
  logic [7:0]            grp;
  logic [7:0]            cont;

  // One right shift per cycle picks the current group, moving on only when step is set
  always_comb begin
    shifted    = v_r >> sh_r;
    pmask      = 8'((9'd1 << p) - 9'd1);
    grp        = shifted[7:0] & pmask;
    cont       = 8'd1 << p;
    final_grp  = (sh_r == '0);
    code_valid = final_grp || started_r || (grp != 8'd0);
    code       = final_grp ? grp : (grp | cont);
  end

  // Value and group position
  always_ff @(posedge clk) begin
    if (load) begin
      v_r  <= value;
      sh_r <= start_sh;
    end else if (step && !final_grp) begin
      sh_r <= sh_r - SHW'(p);
    end
  end

  // Leading zero groups are skipped until the first non-zero one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (load) begin
      started_r <= 1'b0;
    end else if (step && (grp != 8'd0)) begin
      started_r <= 1'b1;
    end
  end

endmodule

// ----- sv/vgbp_byte_packer.sv -----
// Byte packer: merges codes MSB-first into bytes, holds byte 0, builds the flush.
module vgbp_byte_packer
  import vgbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  pk_cmd_t cmd,
  input  logic    apply,
  output pk_res_t res,
  output logic    first_done
);

  logic [7:0] partial_r, partial_nxt;
  logic [3:0] filled_r, filled_nxt;
  logic [7:0] held_r, held_nxt;
  logic       first_done_r, first_done_nxt;

  logic [4:0]  sum;
  logic [15:0] tmp;
  logic [3:0]  rem;
  logic [7:0]  rem_mask;
  logic [2:0]  unused;
  logic [7:0]  fin;
  logic        done_byte;
  logic [7:0]  byte_val;

  always_comb begin
    sum      = 5'(filled_r) + 5'(cmd.width);
    tmp      = (16'(partial_r) << cmd.width) | 16'(cmd.code);
    rem      = 4'(sum - 5'd8);
    rem_mask = 8'((9'd1 << rem) - 9'd1);
    unused   = 3'(4'd8 - filled_r);
    fin      = partial_r << unused;

    partial_nxt    = partial_r;
    filled_nxt     = filled_r;
    held_nxt       = held_r;
    first_done_nxt = first_done_r;
    done_byte      = 1'b0;
    byte_val       = partial_r;
    res            = '0;

    unique case (cmd.op)
      PK_PUSH: begin
        // A full byte leaves only when the next bit needs room
        if (filled_r >= 4'd8) begin
          done_byte   = 1'b1;
          byte_val    = partial_r;
          partial_nxt = cmd.code;
          filled_nxt  = cmd.width;
        end else if (sum <= 5'd8) begin
          partial_nxt = tmp[7:0];
          filled_nxt  = sum[3:0];
        end else begin
          done_byte   = 1'b1;
          byte_val    = 8'(tmp >> rem);
          partial_nxt = tmp[7:0] & rem_mask;
          filled_nxt  = rem;
        end
        if (done_byte) begin
          if (first_done_r) begin
            res.emit = 1'b1;
            res.data = byte_val;
          end else begin
            held_nxt       = byte_val;
            first_done_nxt = 1'b1;
          end
        end
      end
      PK_FLUSH_ONE: begin
        // Byte 0 is also the final byte
        res.emit  = 1'b1;
        res.data  = {1'b0, unused, fin[3:0]};
        res.first = 1'b1;
        res.last  = 1'b1;
      end
      PK_FLUSH_HDR: begin
        res.emit  = 1'b1;
        res.data  = {1'b0, unused, held_r[3:0]};
        res.first = 1'b1;
      end
      PK_FLUSH_FIN: begin
        res.emit = 1'b1;
        res.data = fin;
        res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign first_done = first_done_r;

  // Stream state, back to its start values after a flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r    <= 8'd0;
      filled_r     <= 4'd4;
      held_r       <= 8'd0;
      first_done_r <= 1'b0;
    end else if (apply) begin
      if (cmd.op == PK_FLUSH_ONE || cmd.op == PK_FLUSH_FIN) begin
        partial_r    <= 8'd0;
        filled_r     <= 4'd4;
        held_r       <= 8'd0;
        first_done_r <= 1'b0;
      end else begin
        partial_r    <= partial_nxt;
        filled_r     <= filled_nxt;
        held_r       <= held_nxt;
        first_done_r <= first_done_nxt;
      end
    end
  end

endmodule
